[hw/rtl/cgsd_pkg.sv]
`timescale 1ns / 1ps

package cgsd_pkg;

	localparam int LOGIT_W = 16;
	localparam int POS_W = 13;
	localparam int KEY_W = 14;
	localparam int SUM_W = 32;
	localparam int SUM_FRAC = 16;
	localparam int EXP_W = 17;
	localparam int SCORE_W = 16;
	localparam int DIST_W = 12;
	localparam int EXP_SPAN = 4096;
	localparam int EXP_ARG_W = 13;
	localparam int QUEUE_DEPTH = 2;
	localparam int DIV_STEPS = 17;
	localparam int STEP_W = $clog2(DIV_STEPS);
	localparam int QUOT_W = DIV_STEPS;
	localparam int REM_W = SUM_W + 1;
	localparam int DV_W = SUM_W + SUM_FRAC;

	localparam logic [KEY_W-1:0] KEY_COUNT_RESET = 14'd8192;
	localparam logic [SUM_W-1:0] SUM_ONE = 32'h0001_0000;
	localparam logic [REM_W-1:0] DIV_NUM_ONE = 33'h1_0000_0000;

	typedef struct packed {
		logic [POS_W-1:0] winner;
		logic [SUM_W-1:0] sum;
		logic             first_row;
	} row_end_t;

	typedef struct packed {
		logic full;
		logic empty;
	} q_status_t;

	typedef enum logic {
		F_TAKE,
		F_UPDATE
	} front_phase_t;

	typedef enum logic [1:0] {
		B_IDLE,
		B_DIV,
		B_DONE
	} back_state_t;

	// Evaluates exp(-t/256) in Q16 by a cubic on t/2^20 followed by twelve squarings.
	function automatic logic [EXP_W-1:0] exp_eval_q16(input logic [EXP_ARG_W-1:0] t);
		logic [63:0] a;
		logic [63:0] a2;
		logic [63:0] a3;
		logic [63:0] y;
		a = 64'(t) << 11;
		a2 = (a * a) >> 32;
		a3 = ((a2 * a) >> 31) / 64'd3;
		y = (64'd1 << 31) - a + a2 - a3;
		for (int k = 0; k < 12; k++) begin
			y = (y * y + (64'd1 << 30)) >> 31;
		end
		return EXP_W'((y + (64'd1 << 14)) >> 15);
	endfunction

endpackage

[hw/rtl/cgsd_queue.sv]
`timescale 1ns / 1ps

module cgsd_queue (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 push,
	input  cgsd_pkg::row_end_t   push_data,
	input  logic                 pop,
	output cgsd_pkg::row_end_t   head,
	output cgsd_pkg::q_status_t  q_status
);
	import cgsd_pkg::*;

	localparam int PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
	localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

	row_end_t         entry_q [QUEUE_DEPTH];
	logic [PTR_W-1:0] wr_ptr_q;
	logic [PTR_W-1:0] rd_ptr_q;
	logic [CNT_W-1:0] fill_q;

	assign head = entry_q[rd_ptr_q];
	assign q_status.full = (fill_q == CNT_W'(QUEUE_DEPTH));
	assign q_status.empty = (fill_q == '0);

	always_ff @(posedge clk) begin
		if (push) begin
			entry_q[wr_ptr_q] <= push_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			fill_q <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= (wr_ptr_q == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_q + PTR_W'(1);
			end
			if (pop) begin
				rd_ptr_q <= (rd_ptr_q == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_q + PTR_W'(1);
			end
			if (push && !pop) begin
				fill_q <= fill_q + CNT_W'(1);
			end else if (pop && !push) begin
				fill_q <= fill_q - CNT_W'(1);
			end
		end
	end

endmodule

[hw/rtl/cgsd_front.sv]
`timescale 1ns / 1ps

module cgsd_front #(
	parameter int MAX_CLASSES = 8192,
	parameter int EXP_TABLE_DEPTH = 1024
) (
	input  logic                                 clk,
	input  logic                                 arst_n,
	input  logic                                 in_valid,
	output logic                                 in_stall,
	input  logic signed [cgsd_pkg::LOGIT_W-1:0]  logit,
	input  logic                                 last_in_row,
	input  logic                                 first_row_of_line,
	input  cgsd_pkg::q_status_t                  q_status,
	output logic                                 push,
	output cgsd_pkg::row_end_t                   push_data
);
	import cgsd_pkg::*;

	localparam int CNT_W = $clog2(MAX_CLASSES + 1);
	localparam int IDX_W = $clog2(EXP_TABLE_DEPTH);
	localparam int PROD_W = DIST_W + IDX_W;
	localparam int MUL_W = SUM_W + EXP_W;

	logic [EXP_W-1:0] exp_rom [EXP_TABLE_DEPTH];

	for (genvar g = 0; g < EXP_TABLE_DEPTH; g++) begin : g_rom
		localparam int D0 = (g * EXP_SPAN + EXP_TABLE_DEPTH - 1) / EXP_TABLE_DEPTH;
		assign exp_rom[g] = exp_eval_q16(EXP_ARG_W'(D0));
	end

	front_phase_t                phase_q;
	front_phase_t                phase_d;
	logic                        accept;

	logic signed [LOGIT_W-1:0]   max_q;
	logic [POS_W-1:0]            pos_q;
	logic [CNT_W-1:0]            count_q;
	logic [SUM_W-1:0]            sum_q;

	logic signed [LOGIT_W-1:0]   x_s1;
	logic                        last_s1;
	logic                        first_s1;
	logic                        take_s1;
	logic                        init_s1;
	logic                        gt_s1;
	logic                        big_s1;
	logic [EXP_W-1:0]            e_s1;

	logic signed [LOGIT_W:0]     diff;
	logic                        gt;
	logic [LOGIT_W-1:0]          mag;
	logic [PROD_W-1:0]           prod;
	logic [IDX_W-1:0]            idx;

	logic [EXP_W-1:0]            e;
	logic [MUL_W-1:0]            mul;
	logic [MUL_W-1:0]            rnd;
	logic [SUM_W+1:0]            grow;
	logic [SUM_W:0]              acc;
	logic signed [LOGIT_W-1:0]   max_d;
	logic [POS_W-1:0]            pos_d;
	logic [CNT_W-1:0]            count_d;
	logic [SUM_W-1:0]            sum_d;

	always_comb begin
		phase_d = phase_q;
		in_stall = (phase_q == F_UPDATE) || q_status.full;
		accept = in_valid && !in_stall;
		case (phase_q)
			F_TAKE: begin
				if (accept) begin
					phase_d = F_UPDATE;
				end
			end
			F_UPDATE: begin
				phase_d = F_TAKE;
			end
			default: begin
				phase_d = F_TAKE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= F_TAKE;
		end else begin
			phase_q <= phase_d;
		end
	end

	always_comb begin
		diff = (LOGIT_W + 1)'(logit) - (LOGIT_W + 1)'(max_q);
		gt = !diff[LOGIT_W] && (diff != '0);
		mag = gt ? diff[LOGIT_W-1:0] : LOGIT_W'(-diff);
		prod = PROD_W'(mag[DIST_W-1:0]) * PROD_W'(EXP_TABLE_DEPTH);
		idx = prod[PROD_W-1:DIST_W];
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			x_s1 <= logit;
			last_s1 <= last_in_row;
			first_s1 <= first_row_of_line;
			take_s1 <= (count_q < CNT_W'(MAX_CLASSES));
			init_s1 <= (count_q == '0);
			gt_s1 <= gt;
			big_s1 <= |mag[LOGIT_W-1:DIST_W];
			e_s1 <= exp_rom[idx];
		end
	end

	always_comb begin
		e = big_s1 ? '0 : e_s1;
		mul = MUL_W'(sum_q) * MUL_W'(e);
		rnd = mul + (MUL_W'(1) << (SUM_FRAC - 1));
		grow = (SUM_W + 2)'(rnd[MUL_W-1:SUM_FRAC]) + (SUM_W + 2)'(SUM_ONE);
		acc = (SUM_W + 1)'(sum_q) + (SUM_W + 1)'(e);
		max_d = max_q;
		pos_d = pos_q;
		count_d = count_q;
		sum_d = sum_q;
		if (take_s1) begin
			count_d = count_q + CNT_W'(1);
			if (init_s1) begin
				max_d = x_s1;
				pos_d = '0;
				sum_d = SUM_ONE;
			end else if (gt_s1) begin
				max_d = x_s1;
				pos_d = POS_W'(count_q);
				sum_d = (|grow[SUM_W+1:SUM_W]) ? '1 : grow[SUM_W-1:0];
			end else begin
				sum_d = acc[SUM_W] ? '1 : acc[SUM_W-1:0];
			end
		end
		push = (phase_q == F_UPDATE) && last_s1;
		push_data.winner = pos_d;
		push_data.sum = sum_d;
		push_data.first_row = first_s1;
	end

	always_ff @(posedge clk) begin
		if (phase_q == F_UPDATE) begin
			max_q <= max_d;
			pos_q <= pos_d;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q <= '0;
			sum_q <= '0;
		end else if (phase_q == F_UPDATE) begin
			count_q <= last_s1 ? '0 : count_d;
			sum_q <= last_s1 ? '0 : sum_d;
		end
	end

endmodule

[hw/rtl/cgsd_back.sv]
`timescale 1ns / 1ps

module cgsd_back (
	input  logic                           clk,
	input  logic                           arst_n,
	input  cgsd_pkg::q_status_t            q_status,
	input  cgsd_pkg::row_end_t             head,
	output logic                           pop,
	input  logic [cgsd_pkg::KEY_W-1:0]     key_count,
	output logic                           out_valid,
	input  logic                           out_stall,
	output logic [cgsd_pkg::POS_W-1:0]     key_index,
	output logic [cgsd_pkg::SCORE_W-1:0]   score
);
	import cgsd_pkg::*;

	back_state_t          state_q;
	back_state_t          state_d;
	logic                 load_out;
	logic                 finish;
	logic                 emit;
	logic                 ge;
	logic [SCORE_W-1:0]   score_d;

	logic [POS_W-1:0]     winner_q;
	logic                 first_q;
	logic [REM_W-1:0]     rem_q;
	logic [DV_W-1:0]      dv_q;
	logic [QUOT_W-1:0]    quot_q;
	logic [STEP_W-1:0]    step_q;
	logic [POS_W-1:0]     prev_q;
	logic                 out_valid_q;
	logic [POS_W-1:0]     key_index_q;
	logic [SCORE_W-1:0]   score_q;

	assign out_valid = out_valid_q;
	assign key_index = key_index_q;
	assign score = score_q;

	always_comb begin
		emit = (winner_q != '0) && (KEY_W'(winner_q) < key_count)
			&& (first_q || (winner_q != prev_q));
		ge = DV_W'(rem_q) >= dv_q;
		score_d = quot_q[QUOT_W-1] ? '1 : quot_q[SCORE_W-1:0];
		state_d = state_q;
		pop = 1'b0;
		load_out = 1'b0;
		finish = 1'b0;
		case (state_q)
			B_IDLE: begin
				if (!q_status.empty) begin
					pop = 1'b1;
					state_d = (head.sum == '0) ? B_DONE : B_DIV;
				end
			end
			B_DIV: begin
				if (step_q == '0) begin
					state_d = B_DONE;
				end
			end
			B_DONE: begin
				if (!emit) begin
					finish = 1'b1;
					state_d = B_IDLE;
				end else if (!out_valid_q || !out_stall) begin
					load_out = 1'b1;
					finish = 1'b1;
					state_d = B_IDLE;
				end
			end
			default: begin
				state_d = B_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= B_IDLE;
			prev_q <= '0;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (finish) begin
				prev_q <= winner_q;
			end
			if (load_out) begin
				out_valid_q <= 1'b1;
			end else if (!out_stall) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	// The quotient is formed one bit per cycle, top bit first; a set top bit means saturation.
	always_ff @(posedge clk) begin
		if (pop) begin
			winner_q <= head.winner;
			first_q <= head.first_row;
			rem_q <= DIV_NUM_ONE + REM_W'(head.sum >> 1);
			dv_q <= {head.sum, {SUM_FRAC{1'b0}}};
			step_q <= STEP_W'(DIV_STEPS - 1);
			quot_q <= (head.sum == '0) ? {1'b1, {(QUOT_W - 1){1'b0}}} : '0;
		end else if (state_q == B_DIV) begin
			if (ge) begin
				rem_q <= REM_W'(DV_W'(rem_q) - dv_q);
			end
			quot_q <= {quot_q[QUOT_W-2:0], ge};
			dv_q <= dv_q >> 1;
			step_q <= step_q - STEP_W'(1);
		end
	end

	always_ff @(posedge clk) begin
		if (load_out) begin
			key_index_q <= winner_q - POS_W'(1);
			score_q <= score_d;
		end
	end

endmodule

[hw/rtl/ctc_greedy_softmax_decoder_core.sv]
`timescale 1ns / 1ps
// Each class score is accepted with an exp table read, then updates the running maximum and
// the softmax sum in the F_UPDATE phase; in_stall is high in F_UPDATE and while the queue is
// full, so a new word is taken only after the previous one has been updated. A row end goes
// through a two-entry queue to a divider that forms 1/sum one bit per cycle; the back end pops
// a row end only when idle, divides, and loads an emitted result into the output register. The
// asynchronous active-low reset clears all control state, empties the queue and sets key_count to 8192.

module ctc_greedy_softmax_decoder_core #(
	parameter int MAX_CLASSES = 8192,
	parameter int EXP_TABLE_DEPTH = 1024
) (
	input  logic                                 clk,
	input  logic                                 arst_n,
	input  logic                                 in_valid,
	output logic                                 in_stall,
	input  logic signed [cgsd_pkg::LOGIT_W-1:0]  logit,
	input  logic                                 last_in_row,
	input  logic                                 first_row_of_line,
	output logic                                 out_valid,
	input  logic                                 out_stall,
	output logic [cgsd_pkg::POS_W-1:0]           key_index,
	output logic [cgsd_pkg::SCORE_W-1:0]         score,
	input  logic                                 cfg_valid,
	output logic                                 cfg_ready,
	input  logic [cgsd_pkg::KEY_W-1:0]           key_count
);
	import cgsd_pkg::*;

	logic [KEY_W-1:0] key_count_q;
	logic             push;
	logic             pop;
	row_end_t         push_data;
	row_end_t         head;
	q_status_t        q_status;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			key_count_q <= KEY_COUNT_RESET;
		end else if (cfg_valid && cfg_ready) begin
			key_count_q <= key_count;
		end
	end

	cgsd_front #(
		.MAX_CLASSES     (MAX_CLASSES),
		.EXP_TABLE_DEPTH (EXP_TABLE_DEPTH)
	) u_front (
		.clk               (clk),
		.arst_n            (arst_n),
		.in_valid          (in_valid),
		.in_stall          (in_stall),
		.logit             (logit),
		.last_in_row       (last_in_row),
		.first_row_of_line (first_row_of_line),
		.q_status          (q_status),
		.push              (push),
		.push_data         (push_data)
	);

	cgsd_queue u_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.push_data (push_data),
		.pop       (pop),
		.head      (head),
		.q_status  (q_status)
	);

	cgsd_back u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.q_status  (q_status),
		.head      (head),
		.pop       (pop),
		.key_count (key_count_q),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.key_index (key_index),
		.score     (score)
	);

	assert property (@(posedge clk) disable iff (!arst_n) push |-> !q_status.full)
		else $error("row end pushed into a full queue");

	assert property (@(posedge clk) disable iff (!arst_n) pop |-> !q_status.empty)
		else $error("row end popped from an empty queue");

	assert property (@(posedge clk) disable iff (!arst_n)
		(in_valid && !in_stall) |=> in_stall)
		else $error("word accepted during the update cycle");

	assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> (key_index != '1))
		else $error("key index out of range");

endmodule

[tb/testbench.sv]
`timescale 1ns / 1ps

module testbench;

	import cgsd_pkg::*;

	localparam int CLASS_LIMIT = 8192;
	localparam int TABLE_DEPTH = 1024;
	localparam int SETTLE_CYCLES = 96;
	localparam int PHASE_ITEMS = 60;
	localparam int NUM_PHASES = 8;

	typedef struct packed {
		logic [POS_W-1:0]   key;
		logic [SCORE_W-1:0] prob;
	} decoded_t;

	typedef struct packed {
		logic [LOGIT_W-1:0] logit;
		logic               last;
		logic               first;
		logic               typed;
		logic               hit;
		logic [POS_W-1:0]   key;
		logic [SCORE_W-1:0] prob;
	} dir_row_t;

	// Rows marked typed carry their expected outcome; the others are left to the predictor.
	localparam dir_row_t DIR_ROWS [23] = '{
		'{16'h1234, 1'b1, 1'b1, 1'b1, 1'b0, 13'd0, 16'd0},
		'{16'h8000, 1'b0, 1'b1, 1'b0, 1'b0, 13'd0, 16'd0},
		'{16'h7FFF, 1'b1, 1'b1, 1'b1, 1'b1, 13'd0, 16'd65535},
		'{16'h8000, 1'b0, 1'b0, 1'b0, 1'b0, 13'd0, 16'd0},
		'{16'h7FFF, 1'b1, 1'b0, 1'b1, 1'b0, 13'd0, 16'd0},
		'{16'h8000, 1'b0, 1'b0, 1'b0, 1'b0, 13'd0, 16'd0},
		'{16'h8000, 1'b0, 1'b0, 1'b0, 1'b0, 13'd0, 16'd0},
		'{16'h7FFF, 1'b1, 1'b0, 1'b1, 1'b1, 13'd1, 16'd65535},
		'{16'h0007, 1'b0, 1'b1, 1'b0, 1'b0, 13'd0, 16'd0},
		'{16'h0007, 1'b0, 1'b1, 1'b0, 1'b0, 13'd0, 16'd0},
		'{16'h0007, 1'b1, 1'b1, 1'b1, 1'b0, 13'd0, 16'd0},
		'{16'hFFFF, 1'b0, 1'b1, 1'b0, 1'b0, 13'd0, 16'd0},
		'{16'h0000, 1'b0, 1'b1, 1'b0, 1'b0, 13'd0, 16'd0},
		'{16'h0000, 1'b1, 1'b1, 1'b0, 1'b0, 13'd0, 16'd0},
		'{16'h0000, 1'b0, 1'b0, 1'b0, 1'b0, 13'd0, 16'd0},
		'{16'h0080, 1'b0, 1'b0, 1'b0, 1'b0, 13'd0, 16'd0},
		'{16'h0100, 1'b0, 1'b0, 1'b0, 1'b0, 13'd0, 16'd0},
		'{16'h00C0, 1'b1, 1'b0, 1'b0, 1'b0, 13'd0, 16'd0},
		'{16'h0000, 1'b0, 1'b0, 1'b0, 1'b0, 13'd0, 16'd0},
		'{16'h1000, 1'b0, 1'b0, 1'b0, 1'b0, 13'd0, 16'd0},
		'{16'h0FFF, 1'b1, 1'b0, 1'b0, 1'b0, 13'd0, 16'd0},
		'{16'h0000, 1'b0, 1'b1, 1'b0, 1'b0, 13'd0, 16'd0},
		'{16'h0FFF, 1'b1, 1'b1, 1'b0, 1'b0, 13'd0, 16'd0}
	};

	logic                       clk;
	logic                       arst_n;
	logic                       in_valid;
	logic                       in_stall;
	logic signed [LOGIT_W-1:0]  logit;
	logic                       last_in_row;
	logic                       first_row_of_line;
	logic                       out_valid;
	logic                       out_stall;
	logic [POS_W-1:0]           key_index;
	logic [SCORE_W-1:0]         score;
	logic                       cfg_valid;
	logic                       cfg_ready;
	logic [KEY_W-1:0]           key_count;

	decoded_t          decoded_keys [$];
	longint unsigned   exp_table [EXP_SPAN];
	int                errors;
	bit                sender_calm;

	int                cur_max;
	int unsigned       cur_pos;
	int unsigned       seen_count;
	longint unsigned   soft_sum;
	int unsigned       last_winner;
	int unsigned       keys_loaded;

	ctc_greedy_softmax_decoder_core #(
		.MAX_CLASSES(CLASS_LIMIT),
		.EXP_TABLE_DEPTH(TABLE_DEPTH)
	) uut (
		.clk(clk),
		.arst_n(arst_n),
		.in_valid(in_valid),
		.in_stall(in_stall),
		.logit(logit),
		.last_in_row(last_in_row),
		.first_row_of_line(first_row_of_line),
		.out_valid(out_valid),
		.out_stall(out_stall),
		.key_index(key_index),
		.score(score),
		.cfg_valid(cfg_valid),
		.cfg_ready(cfg_ready),
		.key_count(key_count)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	task automatic flag_error(input string msg);
		errors++;
		$display("ERROR at %0t: %s", $time, msg);
	endtask

	function automatic longint unsigned exp_at(input int delta);
		return (delta >= EXP_SPAN) ? 64'd0 : exp_table[delta];
	endfunction

	function automatic longint unsigned sat32(input longint unsigned v);
		return (v > 64'hFFFF_FFFF) ? 64'hFFFF_FFFF : v;
	endfunction

	task automatic decode_score(input logic [LOGIT_W-1:0] raw, input logic last,
			input logic first, output logic hit, output decoded_t res);
		int x;
		longint unsigned scaled;
		longint unsigned q;
		int unsigned win;
		x = $signed(raw);
		hit = 1'b0;
		res = '0;
		if (seen_count < CLASS_LIMIT) begin
			if (seen_count == 0) begin
				cur_max = x;
				cur_pos = 0;
				soft_sum = 64'd65536;
			end else if (x > cur_max) begin
				scaled = (soft_sum * exp_at(x - cur_max) + 64'd32768) >> 16;
				soft_sum = sat32(scaled + 64'd65536);
				cur_max = x;
				cur_pos = seen_count;
			end else begin
				soft_sum = sat32(soft_sum + exp_at(cur_max - x));
			end
			seen_count++;
		end
		if (last) begin
			win = cur_pos;
			if (soft_sum == 0) begin
				q = 64'd65535;
			end else begin
				q = ((64'd1 << 32) + (soft_sum >> 1)) / soft_sum;
				if (q > 64'd65535)
					q = 64'd65535;
			end
			hit = (win > 0) && (win < keys_loaded) && (first || win != last_winner);
			res.key = POS_W'(win - 1);
			res.prob = SCORE_W'(q);
			last_winner = win;
			seen_count = 0;
			soft_sum = 0;
		end
	endtask

	function automatic int pick_gap();
		int r;
		r = $urandom_range(0, 99);
		if (sender_calm || r < 60)
			return 0;
		if (r < 88)
			return $urandom_range(1, 3);
		if (r < 97)
			return $urandom_range(4, 12);
		return $urandom_range(20, 60);
	endfunction

	task automatic send_word(input logic [LOGIT_W-1:0] v, input logic l, input logic f,
			input logic typed, input logic t_hit, input decoded_t t_res);
		int g;
		logic hit;
		decoded_t res;
		g = pick_gap();
		repeat (g) @(negedge clk) in_valid <= 1'b0;
		@(negedge clk);
		in_valid <= 1'b1;
		logit <= v;
		last_in_row <= l;
		first_row_of_line <= f;
		do @(posedge clk); while (in_stall);
		decode_score(v, l, f, hit, res);
		if (typed) begin
			hit = t_hit;
			res = t_res;
		end
		if (hit)
			decoded_keys.push_back(res);
	endtask

	task automatic settle();
		@(negedge clk) in_valid <= 1'b0;
		while (decoded_keys.size() != 0) @(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	task automatic write_key_count(input logic [KEY_W-1:0] v);
		@(negedge clk);
		cfg_valid <= 1'b1;
		key_count <= v;
		do @(posedge clk); while (!cfg_ready);
		keys_loaded = v;
		@(negedge clk) cfg_valid <= 1'b0;
	endtask

	task automatic random_row(input bit line_start, input int hot, output int len);
		int base;
		int spread;
		int v;
		int star;
		int prev_v;
		int k;
		int r;
		logic f;
		r = $urandom_range(0, 99);
		if (r < 70)
			len = $urandom_range(1, 8);
		else if (r < 95)
			len = $urandom_range(9, 40);
		else
			len = $urandom_range(41, 200);
		case ($urandom_range(0, 3))
			0: spread = 64;
			1: spread = 512;
			2: spread = 2048;
			default: spread = 6000;
		endcase
		base = int'($urandom_range(0, 65535)) - 32768;
		star = -1;
		if ($urandom_range(0, 3) != 0)
			star = (hot < len && $urandom_range(0, 2) != 0) ? hot : $urandom_range(0, len - 1);
		prev_v = base;
		for (k = 0; k < len; k++) begin
			r = $urandom_range(0, 99);
			if (r < 15)
				v = int'($urandom_range(0, 65535)) - 32768;
			else if (r < 25)
				v = prev_v;
			else
				v = base + int'($urandom_range(0, 2 * spread)) - spread;
			if (k == star)
				v = base + spread + int'($urandom_range(0, 255));
			if (v > 32767)
				v = 32767;
			if (v < -32768)
				v = -32768;
			f = line_start;
			if (k != len - 1 && $urandom_range(0, 9) == 0)
				f = ~f;
			send_word(LOGIT_W'(v), k == len - 1, f, 1'b0, 1'b0, '0);
			prev_v = v;
		end
	endtask

	always @(posedge clk) begin : check_out
		decoded_t want;
		if (arst_n && out_valid && !out_stall) begin
			if (decoded_keys.size() == 0) begin
				flag_error($sformatf("unexpected word key=%0d score=%0d", key_index, score));
			end else begin
				want = decoded_keys.pop_front();
				if (key_index !== want.key)
					flag_error($sformatf("key_index %0d, expected %0d", key_index, want.key));
				if (score !== want.prob)
					flag_error($sformatf("score %0d, expected %0d", score, want.prob));
			end
		end
	end

	initial begin
		int r;
		int n;
		logic lvl;
		out_stall = 1'b0;
		forever begin
			r = $urandom_range(0, 99);
			if (r < 50) begin
				lvl = 1'b0;
				n = $urandom_range(1, 8);
			end else if (r < 85) begin
				lvl = 1'b1;
				n = $urandom_range(1, 3);
			end else if (r < 95) begin
				lvl = 1'b1;
				n = $urandom_range(4, 12);
			end else if (r < 98) begin
				lvl = 1'b1;
				n = $urandom_range(20, 60);
			end else begin
				lvl = 1'b0;
				n = $urandom_range(100, 300);
			end
			repeat (n) @(negedge clk) out_stall <= lvl;
		end
	end

	initial begin
		#5_000_000;
		$display("Some tests failed");
		$finish;
	end

	initial begin
		int d;
		int i;
		int phase;
		int phase_items;
		int rows;
		int hot;
		int len;
		longint unsigned bin;
		longint unsigned lo;
		longint unsigned ax;
		longint unsigned a2;
		longint unsigned a3;
		longint unsigned pv;
		logic [KEY_W-1:0] kc;

		clk = 1'b0;
		arst_n = 1'b0;
		in_valid = 1'b0;
		logit = '0;
		last_in_row = 1'b0;
		first_row_of_line = 1'b0;
		cfg_valid = 1'b0;
		key_count = KEY_COUNT_RESET;
		errors = 0;
		sender_calm = 1'b0;

		// exp(-d/256) for every distance, taken at the lower edge of its table bin.
		for (d = 0; d < EXP_SPAN; d++) begin
			bin = (longint'(d) * TABLE_DEPTH) >> 12;
			lo = (bin * 4096 + TABLE_DEPTH - 1) / TABLE_DEPTH;
			if (lo > d)
				lo = d;
			ax = lo << 11;
			a2 = (ax * ax) >> 32;
			a3 = ((a2 * ax) >> 31) / 3;
			pv = (64'd1 << 31) - ax + a2 - a3;
			repeat (12) pv = (pv * pv + (64'd1 << 30)) >> 31;
			exp_table[d] = (pv + (64'd1 << 14)) >> 15;
		end

		cur_max = 0;
		cur_pos = 0;
		seen_count = 0;
		soft_sum = 0;
		last_winner = 0;
		keys_loaded = KEY_COUNT_RESET;

		repeat (2) @(posedge clk);
		@(negedge clk) arst_n <= 1'b1;

		for (i = 0; i < 23; i++)
			send_word(DIR_ROWS[i].logit, DIR_ROWS[i].last, DIR_ROWS[i].first,
				DIR_ROWS[i].typed, DIR_ROWS[i].hit, '{DIR_ROWS[i].key, DIR_ROWS[i].prob});

		for (phase = 0; phase < NUM_PHASES; phase++) begin
			settle();
			case (phase)
				0: kc = KEY_COUNT_RESET;
				1: kc = '0;
				2: kc = KEY_W'(1);
				3: kc = KEY_W'(3);
				4: kc = '1;
				5: kc = KEY_W'($urandom_range(2, 40));
				6: kc = KEY_COUNT_RESET;
				default: kc = KEY_W'($urandom_range(0, 16383));
			endcase
			write_key_count(kc);
			sender_calm = ($urandom_range(0, 3) == 0);
			phase_items = 0;
			while (phase_items < PHASE_ITEMS) begin
				rows = $urandom_range(1, 6);
				hot = $urandom_range(0, 7);
				for (i = 0; i < rows; i++) begin
					random_row(i == 0, hot, len);
					phase_items += len;
				end
			end
		end

		settle();
		if (errors == 0)
			$display("All tests passed");
		else
			$display("Some tests failed");
		$finish;
	end

endmodule
